@@ sv/assert_macros.svh @@
// Assertion macros shared by the calendar clock counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define CCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define CCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/ccc_pkg.sv @@
// Types, constants and calendar helper functions for the calendar clock counter.
package ccc_pkg;

    localparam logic [11:0] YEAR_MIN  = 12'd2000;
    localparam logic [11:0] YEAR_MAX  = 12'd3000;
    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_MAR = 4'd3;
    localparam logic [3:0]  MONTH_MAY = 4'd5;
    localparam logic [3:0]  MONTH_AUG = 4'd8;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [4:0]  HOUR_MAX  = 5'd23;
    localparam logic [5:0]  MIN_MAX   = 6'd59;
    localparam logic [5:0]  SEC_MAX   = 6'd59;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_LOAD       = 3'd1,
        OP_NEXT_MONTH = 3'd2,
        OP_PREV_MONTH = 3'd3,
        OP_NEXT_YEAR  = 3'd4,
        OP_PREV_YEAR  = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        SEASON_WINTER = 2'd0,
        SEASON_SPRING = 2'd1,
        SEASON_SUMMER = 2'd2,
        SEASON_AUTUMN = 2'd3
    } t_season;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_date_time;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_load;

    typedef struct packed {
        logic [2:0] weekday;
        logic [2:0] first_weekday;
        logic [4:0] month_length;
        logic       leap_flag;
        logic [1:0] season;
    } t_derived;

    typedef struct packed {
        t_date_time now;
        t_derived   cal;
    } t_result;

    localparam t_date_time RESET_STATE = '{
        year: 12'd2000, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd1
    };

    // Gregorian leap test, valid for years 1801..3099 only
    function automatic logic is_leap(input logic [11:0] y);
        logic common_century;
        common_century = (y == 12'd1900) || (y == 12'd2100) || (y == 12'd2200) ||
                         (y == 12'd2300) || (y == 12'd2500) || (y == 12'd2600) ||
                         (y == 12'd2700) || (y == 12'd2900) || (y == 12'd3000);
        return (y[1:0] == 2'b00) && !common_century;
    endfunction

    // Days in month m of year y; out-of-range months count as 31
    function automatic logic [4:0] month_len(input logic [11:0] y, input logic [3:0] m);
        logic [4:0] len;
        if (m == MONTH_FEB) begin
            len = is_leap(y) ? 5'd29 : 5'd28;
        end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

    // Month offsets of the Sakamoto weekday formula
    function automatic logic [2:0] sak_offset(input logic [3:0] m);
        logic [2:0] off;
        case (m)
            4'd1:    off = 3'd0;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    // Whole centuries in yy, for yy in 1900..3099
    function automatic logic [4:0] century(input logic [11:0] yy);
        logic [4:0] c;
        c = 5'd19;
        for (int k = 20; k <= 30; k++) begin
            if (yy >= 12'(k * 100)) begin
                c = 5'(k);
            end
        end
        return c;
    endfunction

    // Remainder by seven: octal digits fold since eight leaves one
    function automatic logic [2:0] mod7(input logic [11:0] x);
        logic [4:0] f1;
        logic [3:0] f2;
        f1 = 5'(x[11:9]) + 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
        f2 = 4'(f1[4:3]) + 4'(f1[2:0]);
        return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
    endfunction

    // Meteorological season of a month
    function automatic t_season season_of(input logic [3:0] m);
        t_season s;
        if (m == MONTH_DEC || m <= MONTH_FEB) begin
            s = SEASON_WINTER;
        end else if (m <= MONTH_MAY) begin
            s = SEASON_SPRING;
        end else if (m <= MONTH_AUG) begin
            s = SEASON_SUMMER;
        end else begin
            s = SEASON_AUTUMN;
        end
        return s;
    endfunction

endpackage

@@ sv/ccc_in_if.sv @@
// Command channel of the calendar clock counter: valid, ready and command payload.
interface ccc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [11:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;

    modport source (
        output valid, opcode, load_year, load_month, load_day,
        output load_hour, load_minute, load_second,
        input  ready
    );

    modport sink (
        input  valid, opcode, load_year, load_month, load_day,
        input  load_hour, load_minute, load_second,
        output ready
    );
endinterface

@@ sv/ccc_out_if.sv @@
// Result channel of the calendar clock counter: valid, ready and date report payload.
interface ccc_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [2:0]  weekday;
    logic [2:0]  first_weekday;
    logic [4:0]  month_length;
    logic        leap_flag;
    logic [1:0]  season;

    modport source (
        output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
        output weekday, first_weekday, month_length, leap_flag, season,
        input  ready
    );

    modport sink (
        input  valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
        input  weekday, first_weekday, month_length, leap_flag, season,
        output ready
    );
endinterface

@@ sv/ccc_next.sv @@
// Next date and time of the calendar clock counter for one command.
module ccc_next (
    input  ccc_pkg::t_date_time i_state,
    input  logic [2:0]          i_opcode,
    input  ccc_pkg::t_load      i_load,
    output ccc_pkg::t_date_time o_state
);

    ccc_pkg::t_date_time tick_state;
    ccc_pkg::t_date_time load_state;
    ccc_pkg::t_date_time step_state;
    logic                at_end;
    logic [4:0]          load_len;
    logic [4:0]          step_len;

    // Advance one second with carries; hold at the last second of the range
    always_comb begin
        tick_state = i_state;
        at_end = (i_state.year >= ccc_pkg::YEAR_MAX) && (i_state.month == ccc_pkg::MONTH_DEC) &&
                 (i_state.day == 5'd31) && (i_state.hour == ccc_pkg::HOUR_MAX) &&
                 (i_state.minute == ccc_pkg::MIN_MAX) && (i_state.second == ccc_pkg::SEC_MAX);
        if (!at_end) begin
            if (i_state.second < ccc_pkg::SEC_MAX) begin
                tick_state.second = i_state.second + 6'd1;
            end else begin
                tick_state.second = 6'd0;
                if (i_state.minute < ccc_pkg::MIN_MAX) begin
                    tick_state.minute = i_state.minute + 6'd1;
                end else begin
                    tick_state.minute = 6'd0;
                    if (i_state.hour < ccc_pkg::HOUR_MAX) begin
                        tick_state.hour = i_state.hour + 5'd1;
                    end else begin
                        tick_state.hour = 5'd0;
                        if (i_state.day < ccc_pkg::month_len(i_state.year, i_state.month)) begin
                            tick_state.day = i_state.day + 5'd1;
                        end else begin
                            tick_state.day = 5'd1;
                            if (i_state.month < ccc_pkg::MONTH_DEC) begin
                                tick_state.month = i_state.month + 4'd1;
                            end else begin
                                tick_state.month = ccc_pkg::MONTH_JAN;
                                tick_state.year  = i_state.year + 12'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    // Clamp every loaded field into range
    always_comb begin
        if (i_load.year < ccc_pkg::YEAR_MIN) begin
            load_state.year = ccc_pkg::YEAR_MIN;
        end else if (i_load.year > ccc_pkg::YEAR_MAX) begin
            load_state.year = ccc_pkg::YEAR_MAX;
        end else begin
            load_state.year = i_load.year;
        end
        if (i_load.month < ccc_pkg::MONTH_JAN) begin
            load_state.month = ccc_pkg::MONTH_JAN;
        end else if (i_load.month > ccc_pkg::MONTH_DEC) begin
            load_state.month = ccc_pkg::MONTH_DEC;
        end else begin
            load_state.month = i_load.month;
        end
        load_len = ccc_pkg::month_len(load_state.year, load_state.month);
        if (i_load.day == 5'd0) begin
            load_state.day = 5'd1;
        end else if (i_load.day > load_len) begin
            load_state.day = load_len;
        end else begin
            load_state.day = i_load.day;
        end
        load_state.hour   = (i_load.hour > ccc_pkg::HOUR_MAX) ? ccc_pkg::HOUR_MAX : i_load.hour;
        load_state.minute = (i_load.minute > ccc_pkg::MIN_MAX) ? ccc_pkg::MIN_MAX : i_load.minute;
        load_state.second = (i_load.second > ccc_pkg::SEC_MAX) ? ccc_pkg::SEC_MAX : i_load.second;
    end

    // Step month or year with saturation, then fit the day into the new month
    always_comb begin
        step_state = i_state;
        case (i_opcode)
            ccc_pkg::OP_NEXT_MONTH: begin
                if (i_state.month >= ccc_pkg::MONTH_DEC) begin
                    step_state.month = ccc_pkg::MONTH_JAN;
                    if (i_state.year < ccc_pkg::YEAR_MAX) begin
                        step_state.year = i_state.year + 12'd1;
                    end
                end else begin
                    step_state.month = i_state.month + 4'd1;
                end
            end
            ccc_pkg::OP_PREV_MONTH: begin
                if (i_state.month <= ccc_pkg::MONTH_JAN) begin
                    step_state.month = ccc_pkg::MONTH_DEC;
                    if (i_state.year > ccc_pkg::YEAR_MIN) begin
                        step_state.year = i_state.year - 12'd1;
                    end
                end else begin
                    step_state.month = i_state.month - 4'd1;
                end
            end
            ccc_pkg::OP_NEXT_YEAR: begin
                if (i_state.year < ccc_pkg::YEAR_MAX) begin
                    step_state.year = i_state.year + 12'd1;
                end
            end
            ccc_pkg::OP_PREV_YEAR: begin
                if (i_state.year > ccc_pkg::YEAR_MIN) begin
                    step_state.year = i_state.year - 12'd1;
                end
            end
            default: begin
                step_state = i_state;
            end
        endcase
        step_len = ccc_pkg::month_len(step_state.year, step_state.month);
        if (i_state.day == 5'd0) begin
            step_state.day = 5'd1;
        end else if (i_state.day > step_len) begin
            step_state.day = step_len;
        end
    end

    // Select the result of the command; unused codes keep the state
    always_comb begin
        case (i_opcode)
            ccc_pkg::OP_TICK:       o_state = tick_state;
            ccc_pkg::OP_LOAD:       o_state = load_state;
            ccc_pkg::OP_NEXT_MONTH,
            ccc_pkg::OP_PREV_MONTH,
            ccc_pkg::OP_NEXT_YEAR,
            ccc_pkg::OP_PREV_YEAR:  o_state = step_state;
            default:                o_state = i_state;
        endcase
    end

endmodule

@@ sv/ccc_derive.sv @@
// Calendar facts of a date: weekdays, month length, leap flag and season.
module ccc_derive (
    input  ccc_pkg::t_date_time i_date,
    output ccc_pkg::t_derived   o_cal
);

    logic [11:0] adj_year;
    logic [4:0]  cent;
    logic [11:0] year_term;
    logic [11:0] day_sum;
    logic [11:0] first_sum;
    logic [11:0] month_off;

    // Sakamoto: count January and February in the previous year
    always_comb begin
        adj_year  = (i_date.month < ccc_pkg::MONTH_MAR) ? i_date.year - 12'd1 : i_date.year;
        cent      = ccc_pkg::century(adj_year);
        year_term = adj_year + {2'b00, adj_year[11:2]} + 12'(cent[4:2]) - 12'(cent);
        month_off = 12'(ccc_pkg::sak_offset(i_date.month));
        day_sum   = year_term + month_off + 12'(i_date.day);
        first_sum = year_term + month_off + 12'd1;
    end

    // Reduce to weekdays and collect the remaining facts
    always_comb begin
        o_cal.weekday       = ccc_pkg::mod7(day_sum);
        o_cal.first_weekday = ccc_pkg::mod7(first_sum);
        o_cal.month_length  = ccc_pkg::month_len(i_date.year, i_date.month);
        o_cal.leap_flag     = ccc_pkg::is_leap(i_date.year);
        o_cal.season        = ccc_pkg::season_of(i_date.month);
    end

endmodule

@@ sv/calendar_clock_counter.sv @@
// Top level of the calendar clock counter: state register, report stage and handshakes.
//
// Calendar clock counter. Takes one command per transaction on i_in (tick one
// second, load, next or previous month, next or previous year) and returns one
// report per command on o_out: the date and time after the command, the weekday,
// the weekday of the first of the month, the month length, the leap flag and the
// season. Dates stay within 2000-01-01 and 3000-12-31; a tick at the last second
// of that range holds the clock. A command is accepted every cycle unless the
// report channel stalls: the clamp and carry logic writes the date and time
// register in the accepting cycle, and the calendar arithmetic fills the output
// register from it once that register is free. Ready drops only while both the
// date register and the output register hold unconsumed transactions.
`include "assert_macros.svh"

module calendar_clock_counter (
    input logic       i_clk,
    input logic       i_rst_n,
    ccc_in_if.sink    i_in,
    ccc_out_if.source o_out
);

    ccc_pkg::t_date_time r_state;
    ccc_pkg::t_date_time n_state;
    logic                r_s1_valid;
    logic                r_out_valid;
    ccc_pkg::t_result    r_out;
    ccc_pkg::t_load      load_cmd;
    ccc_pkg::t_derived   cal_info;
    logic                in_fire;
    logic                out_free;
    logic                s1_move;

    // Gather the load fields
    assign load_cmd = '{
        year:   i_in.load_year,
        month:  i_in.load_month,
        day:    i_in.load_day,
        hour:   i_in.load_hour,
        minute: i_in.load_minute,
        second: i_in.load_second
    };

    ccc_next u_next (
        .i_state  (r_state),
        .i_opcode (i_in.opcode),
        .i_load   (load_cmd),
        .o_state  (n_state)
    );

    ccc_derive u_derive (
        .i_date (r_state),
        .o_cal  (cal_info)
    );

    // Pipeline flow control
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_move    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_fire    = i_in.valid && i_in.ready;

    // Update the date and time; track which stages hold a transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ccc_pkg::RESET_STATE;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the report
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= '{now: r_state, cal: cal_info};
        end
    end

    // Drive the result channel
    assign o_out.valid         = r_out_valid;
    assign o_out.cur_year      = r_out.now.year;
    assign o_out.cur_month     = r_out.now.month;
    assign o_out.cur_day       = r_out.now.day;
    assign o_out.cur_hour      = r_out.now.hour;
    assign o_out.cur_minute    = r_out.now.minute;
    assign o_out.cur_second    = r_out.now.second;
    assign o_out.weekday       = r_out.cal.weekday;
    assign o_out.first_weekday = r_out.cal.first_weekday;
    assign o_out.month_length  = r_out.cal.month_length;
    assign o_out.leap_flag     = r_out.cal.leap_flag;
    assign o_out.season        = r_out.cal.season;

    // Checks
    `CCC_ASSERT(a_state_in_range, (r_state.year >= ccc_pkg::YEAR_MIN) && (r_state.year <= ccc_pkg::YEAR_MAX) && (r_state.month >= ccc_pkg::MONTH_JAN) && (r_state.month <= ccc_pkg::MONTH_DEC) && (r_state.day >= 5'd1) && (r_state.day <= ccc_pkg::month_len(r_state.year, r_state.month)) && (r_state.hour <= ccc_pkg::HOUR_MAX) && (r_state.minute <= ccc_pkg::MIN_MAX) && (r_state.second <= ccc_pkg::SEC_MAX), "date and time register out of range")
    `CCC_ASSERT(a_step_keeps_time, (in_fire && (i_in.opcode != ccc_pkg::OP_TICK) && (i_in.opcode != ccc_pkg::OP_LOAD)) |=> ($stable(r_state.hour) && $stable(r_state.minute) && $stable(r_state.second)), "month or year step changed the time of day")
    `CCC_ASSERT(a_report_sane, r_out_valid |-> ((r_out.cal.weekday < 3'd7) && (r_out.cal.first_weekday < 3'd7) && (r_out.cal.month_length >= 5'd28) && (r_out.cal.month_length <= 5'd31)), "calendar report out of range")
    `CCC_ASSERT(a_stall_holds_state, (r_s1_valid && !out_free) |=> $stable(r_state), "date register changed while its report was stalled")
    `CCC_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> (!r_s1_valid && !r_out_valid), "pipeline not empty after reset")

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the calendar clock counter: directed commands, then random traffic.
module tb_top;
    import ccc_pkg::*;

    // Opcodes the block leaves unused; it must report the date unchanged
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS_PER_PHASE = 470;
    localparam int DRAIN_CYCLES           = 8;

    logic i_clk;
    logic i_rst_n;

    ccc_in_if  cmd_if ();
    ccc_out_if rpt_if ();

    calendar_clock_counter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (rpt_if)
    );

    t_date_time clock_now;
    t_result    expected_reports[$];
    int         mismatch_count = 0;
    int         items_sent     = 0;
    int         tx_idle_pct    = 0;
    int         rx_idle_pct    = 0;
    int         weekday_shift[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run in case the block stops answering
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in(input int y, input int m);
        int len;
        case (m)
            MONTH_FEB:       len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:     len = 30;
            default:         len = 31;
        endcase
        return len;
    endfunction

    function automatic int clamp_to(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Weekday with the year shifted back for January and February, 0 is Sunday
    function automatic int weekday_of(input int y, input int m, input int d);
        int yy;
        yy = (m < MONTH_MAR) ? y - 1 : y;
        return (yy + yy / 4 - yy / 100 + yy / 400 + weekday_shift[m - 1] + d) % 7;
    endfunction

    // Apply one command to the tracked clock and build the report it should produce
    function automatic t_result advance_calendar(input logic [2:0] op, input t_load ld);
        int      y, m, d, h, mi, s;
        t_result rpt;
        y  = clock_now.year;
        m  = clock_now.month;
        d  = clock_now.day;
        h  = clock_now.hour;
        mi = clock_now.minute;
        s  = clock_now.second;
        case (op)
            OP_TICK: begin
                // Hold at the last second of the range, otherwise ripple the carry
                if (!(y == YEAR_MAX && m == MONTH_DEC && d == days_in(y, m) &&
                      h == HOUR_MAX && mi == MIN_MAX && s == SEC_MAX)) begin
                    s++;
                    if (s > SEC_MAX) begin
                        s = 0;
                        mi++;
                    end
                    if (mi > MIN_MAX) begin
                        mi = 0;
                        h++;
                    end
                    if (h > HOUR_MAX) begin
                        h = 0;
                        d++;
                    end
                    if (d > days_in(y, m)) begin
                        d = 1;
                        m++;
                    end
                    if (m > MONTH_DEC) begin
                        m = MONTH_JAN;
                        y++;
                    end
                end
            end
            OP_LOAD: begin
                y  = clamp_to(ld.year, YEAR_MIN, YEAR_MAX);
                m  = clamp_to(ld.month, MONTH_JAN, MONTH_DEC);
                d  = ld.day;
                h  = clamp_to(ld.hour, 0, HOUR_MAX);
                mi = clamp_to(ld.minute, 0, MIN_MAX);
                s  = clamp_to(ld.second, 0, SEC_MAX);
            end
            OP_NEXT_MONTH: begin
                if (m == MONTH_DEC) begin
                    m = MONTH_JAN;
                    if (y < YEAR_MAX) y++;
                end else begin
                    m++;
                end
            end
            OP_PREV_MONTH: begin
                if (m == MONTH_JAN) begin
                    m = MONTH_DEC;
                    if (y > YEAR_MIN) y--;
                end else begin
                    m--;
                end
            end
            OP_NEXT_YEAR: begin
                if (y < YEAR_MAX) y++;
            end
            OP_PREV_YEAR: begin
                if (y > YEAR_MIN) y--;
            end
            default: begin
            end
        endcase
        d = clamp_to(d, 1, days_in(y, m));

        clock_now.year   = 12'(y);
        clock_now.month  = 4'(m);
        clock_now.day    = 5'(d);
        clock_now.hour   = 5'(h);
        clock_now.minute = 6'(mi);
        clock_now.second = 6'(s);

        rpt.now               = clock_now;
        rpt.cal.weekday       = 3'(weekday_of(y, m, d));
        rpt.cal.first_weekday = 3'(weekday_of(y, m, 1));
        rpt.cal.month_length  = 5'(days_in(y, m));
        rpt.cal.leap_flag     = leap_year(y);
        // December wraps to zero so winter lands on Dec, Jan, Feb
        rpt.cal.season        = 2'((m % 12) / 3);
        return rpt;
    endfunction

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Predict on every accepted command, check every accepted report
    always @(posedge i_clk) begin
        t_load   ld;
        t_result want;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                ld.year   = cmd_if.load_year;
                ld.month  = cmd_if.load_month;
                ld.day    = cmd_if.load_day;
                ld.hour   = cmd_if.load_hour;
                ld.minute = cmd_if.load_minute;
                ld.second = cmd_if.load_second;
                expected_reports.push_back(advance_calendar(cmd_if.opcode, ld));
            end
            if (rpt_if.valid && rpt_if.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("report transaction with no command outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("cur_year", want.now.year, rpt_if.cur_year);
                    check_field("cur_month", want.now.month, rpt_if.cur_month);
                    check_field("cur_day", want.now.day, rpt_if.cur_day);
                    check_field("cur_hour", want.now.hour, rpt_if.cur_hour);
                    check_field("cur_minute", want.now.minute, rpt_if.cur_minute);
                    check_field("cur_second", want.now.second, rpt_if.cur_second);
                    check_field("weekday", want.cal.weekday, rpt_if.weekday);
                    check_field("first_weekday", want.cal.first_weekday,
                                rpt_if.first_weekday);
                    check_field("month_length", want.cal.month_length,
                                rpt_if.month_length);
                    check_field("leap_flag", want.cal.leap_flag, rpt_if.leap_flag);
                    check_field("season", want.cal.season, rpt_if.season);
                end
            end
        end
    end

    // Stall the report channel at the current rate
    always @(negedge i_clk) begin
        rpt_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic t_load make_load(input int y, input int m, input int d,
                                        input int h, input int mi, input int s);
        t_load ld;
        ld.year   = 12'(y);
        ld.month  = 4'(m);
        ld.day    = 5'(d);
        ld.hour   = 5'(h);
        ld.minute = 6'(mi);
        ld.second = 6'(s);
        return ld;
    endfunction

    function automatic t_load random_fields();
        return make_load($urandom_range(4095), $urandom_range(15), $urandom_range(31),
                         $urandom_range(31), $urandom_range(63), $urandom_range(63));
    endfunction

    // Pick a date and time a second or so short of a rollover
    function automatic t_load near_rollover();
        int y, m, d, h, mi, s;
        case ($urandom_range(5))
            0:       y = YEAR_MIN;
            1:       y = YEAR_MAX;
            2:       y = $urandom_range(20, 30) * 100 - $urandom_range(1);
            default: y = $urandom_range(YEAR_MIN, YEAR_MAX);
        endcase
        m = $urandom_range(MONTH_JAN, MONTH_DEC);
        case ($urandom_range(2))
            0:       d = days_in(y, m);
            1:       d = days_in(y, m) - 1;
            default: d = $urandom_range(1, 31);
        endcase
        h  = $urandom_range(1) ? HOUR_MAX : $urandom_range(HOUR_MAX);
        mi = $urandom_range(1) ? MIN_MAX : $urandom_range(MIN_MAX);
        s  = $urandom_range(1) ? SEC_MAX - $urandom_range(1) : $urandom_range(SEC_MAX);
        return make_load(y, m, d, h, mi, s);
    endfunction

    // Offer one command and hold it until the block takes it
    task automatic send_cmd(input logic [2:0] op, input t_load ld);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.opcode      <= op;
        cmd_if.load_year   <= ld.year;
        cmd_if.load_month  <= ld.month;
        cmd_if.load_day    <= ld.day;
        cmd_if.load_hour   <= ld.hour;
        cmd_if.load_minute <= ld.minute;
        cmd_if.load_second <= ld.second;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Drop valid and wait for every outstanding report
    task automatic wait_drained();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_unused_opcodes();
        send_cmd(OP_SPARE_6, random_fields());
        send_cmd(OP_SPARE_7, random_fields());
    endtask

    task automatic test_load_clamps();
        send_cmd(OP_LOAD, make_load(0, 0, 0, 0, 0, 0));
        send_cmd(OP_LOAD, make_load(4095, 15, 31, 31, 63, 63));
    endtask

    task automatic test_tick_carries();
        // Carry through every field into the next century
        send_cmd(OP_LOAD, make_load(2099, 12, 31, 23, 59, 59));
        send_cmd(OP_TICK, make_load(0, 0, 0, 0, 0, 0));
        // Leap February of a divisible-by-400 year
        send_cmd(OP_LOAD, make_load(2000, 2, 28, 23, 59, 59));
        send_cmd(OP_TICK, make_load(4095, 15, 31, 31, 63, 63));
        // Common February of a century year
        send_cmd(OP_LOAD, make_load(2100, 2, 28, 23, 59, 59));
        send_cmd(OP_TICK, random_fields());
        // Saturate at the last second of the range
        send_cmd(OP_LOAD, make_load(3000, 12, 31, 23, 59, 59));
        send_cmd(OP_TICK, random_fields());
    endtask

    task automatic test_month_steps();
        send_cmd(OP_LOAD, make_load(3000, 12, 15, 8, 0, 0));
        send_cmd(OP_NEXT_MONTH, random_fields());
        send_cmd(OP_LOAD, make_load(2000, 1, 31, 8, 0, 0));
        send_cmd(OP_PREV_MONTH, random_fields());
        send_cmd(OP_LOAD, make_load(2004, 1, 31, 8, 0, 0));
        send_cmd(OP_NEXT_MONTH, random_fields());
    endtask

    task automatic test_year_steps();
        send_cmd(OP_NEXT_YEAR, random_fields());
        send_cmd(OP_LOAD, make_load(3000, 6, 30, 12, 30, 30));
        send_cmd(OP_NEXT_YEAR, random_fields());
        send_cmd(OP_LOAD, make_load(2000, 2, 29, 12, 30, 30));
        send_cmd(OP_PREV_YEAR, random_fields());
    endtask

    // Mostly rollover and step sequences, with raw loads and spare opcodes mixed in
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        int target;
        int kind;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = items_sent + count;
        while (items_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                send_cmd(OP_LOAD, near_rollover());
                repeat ($urandom_range(1, 4)) send_cmd(OP_TICK, random_fields());
            end else if (kind < 65) begin
                repeat ($urandom_range(1, 6)) begin
                    send_cmd(3'($urandom_range(int'(OP_NEXT_MONTH), int'(OP_PREV_YEAR))),
                             random_fields());
                end
            end else if (kind < 80) begin
                send_cmd(OP_LOAD, random_fields());
                repeat ($urandom_range(1, 3)) begin
                    send_cmd(3'($urandom_range(int'(OP_TICK), int'(OP_PREV_YEAR))),
                             random_fields());
                end
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 8)) send_cmd(OP_TICK, random_fields());
            end else begin
                send_cmd(3'($urandom_range(7)), random_fields());
            end
        end
        wait_drained();
    endtask

    // Reset, run the tests in turn, then report
    initial begin
        i_rst_n            = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.opcode      = OP_TICK;
        cmd_if.load_year   = '0;
        cmd_if.load_month  = '0;
        cmd_if.load_day    = '0;
        cmd_if.load_hour   = '0;
        cmd_if.load_minute = '0;
        cmd_if.load_second = '0;
        rpt_if.ready       = 1'b0;
        clock_now          = make_load(2000, 1, 1, 0, 0, 1);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_unused_opcodes();
        test_load_clamps();
        test_tick_carries();
        test_month_steps();
        test_year_steps();
        wait_drained();

        test_random_traffic(32, 79, RANDOM_ITEMS_PER_PHASE);
        test_random_traffic(79, 32, RANDOM_ITEMS_PER_PHASE);
        test_random_traffic(0, 0, RANDOM_ITEMS_PER_PHASE);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
